// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The condition must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: sv/tilu_pkg.sv
`default_nettype none

package tilu_pkg;

	// Fixed field widths of the stream payloads.
	localparam int MODE_W   = 2;
	localparam int LETTER_W = 5;
	localparam int STATUS_W = 3;

	// Request kinds carried in tuser.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_IGNORE = 2'd3
	} mode_t;

	// Result codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_POOL_FULL = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	// Result handed from the controller to the output register.
	typedef struct packed {
		logic    vld;
		status_t status;
	} res_t;

endpackage

`default_nettype wire

// File: sv/trie_insert_lookup_unit.sv
// Channel  Group   Accepted when          Payload
// -------  ------  ---------------------  ----------------------------------------
// input    s_axis  s_axis_tvalid&tready   tdata letter, tlast last_letter, tuser mode
// output   m_axis  m_axis_tvalid&tready   tdata status
//
// For a letter, the accept cycle issues the reads of the cursor's node
// entry and child link, and the next cycle decides on the returned data.
// An extra step follows when a node is allocated (the fresh node's entry is written
// through the single node-memory write port) or when a find ends on a child
// (its word mark is read back first). Clear and ignored requests add no step.
// Reset needs no clearing pass: nodes are written as they are allocated and the
// root is masked as empty until written. A stalled output holds the deciding
// cycle; one finished result waits in the output register while the next
// request is taken.
`default_nettype none
`include "assert_macros.svh"

module trie_insert_lookup_unit #(
	parameter int NODE_COUNT    = 256,
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [4:0] letter, [7:5] zero
	input  wire logic       s_axis_tlast,
	input  wire logic [1:0] s_axis_tuser,  // [1:0] mode
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata   // [2:0] status, [7:3] zero
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int LTR_W  = $clog2(ALPHABET_SIZE);

	tilu_pkg::res_t                 res;
	logic                           out_busy;
	logic                           out_valid_q;
	tilu_pkg::status_t              status_q;

	logic                           ch_rd_en, ch_wr_en;
	logic [NODE_W+LTR_W-1:0]        ch_rd_addr, ch_wr_addr;
	logic [NODE_W-1:0]              ch_rd_data, ch_wr_data;
	logic                           nd_rd_en, nd_wr_pres_en, nd_wr_we_en;
	logic [NODE_W-1:0]              nd_rd_addr, nd_wr_addr;
	logic [ALPHABET_SIZE-1:0]       nd_rd_pres, nd_wr_pres;
	logic                           nd_rd_we, nd_wr_we;

	tilu_ctrl #(
		.NODE_COUNT   (NODE_COUNT),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_mode      (tilu_pkg::mode_t'(s_axis_tuser)),
		.in_letter    (s_axis_tdata[tilu_pkg::LETTER_W-1:0]),
		.in_last      (s_axis_tlast),
		.out_busy     (out_busy),
		.res          (res),
		.ch_rd_en     (ch_rd_en),
		.ch_rd_addr   (ch_rd_addr),
		.ch_rd_data   (ch_rd_data),
		.ch_wr_en     (ch_wr_en),
		.ch_wr_addr   (ch_wr_addr),
		.ch_wr_data   (ch_wr_data),
		.nd_rd_en     (nd_rd_en),
		.nd_rd_addr   (nd_rd_addr),
		.nd_rd_pres   (nd_rd_pres),
		.nd_rd_we     (nd_rd_we),
		.nd_wr_pres_en(nd_wr_pres_en),
		.nd_wr_we_en  (nd_wr_we_en),
		.nd_wr_addr   (nd_wr_addr),
		.nd_wr_pres   (nd_wr_pres),
		.nd_wr_we     (nd_wr_we)
	);

	tilu_child_mem #(
		.ADDR_W(NODE_W + LTR_W),
		.DATA_W(NODE_W)
	) u_child_mem (
		.clk    (clk),
		.rd_en  (ch_rd_en),
		.rd_addr(ch_rd_addr),
		.rd_data(ch_rd_data),
		.wr_en  (ch_wr_en),
		.wr_addr(ch_wr_addr),
		.wr_data(ch_wr_data)
	);

	tilu_node_mem #(
		.ADDR_W(NODE_W),
		.PRES_W(ALPHABET_SIZE)
	) u_node_mem (
		.clk       (clk),
		.rd_en     (nd_rd_en),
		.rd_addr   (nd_rd_addr),
		.rd_pres   (nd_rd_pres),
		.rd_we     (nd_rd_we),
		.wr_pres_en(nd_wr_pres_en),
		.wr_we_en  (nd_wr_we_en),
		.wr_addr   (nd_wr_addr),
		.wr_pres   (nd_wr_pres),
		.wr_we     (nd_wr_we)
	);

	// The output register cannot take a new result while its current one is
	// still waiting.
	assign out_busy = out_valid_q && !m_axis_tready;

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.vld) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res.vld) begin
			status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, status_q};

	`ASSERT_CLK(a_no_overwrite, res.vld |-> (!out_valid_q || m_axis_tready),
		"result written over a waiting result")

endmodule

`default_nettype wire

// File: sv/tilu_child_mem.sv
`default_nettype none

// Child link table: one entry per node and letter slot, registered read.
module tilu_child_mem #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/tilu_node_mem.sv
`default_nettype none

// Per-node entry: child present mask and word mark, with a write enable per
// field so that either can be updated without a read-modify-write.
module tilu_node_mem #(
	parameter int ADDR_W = 8,
	parameter int PRES_W = 26
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [PRES_W-1:0] rd_pres,
	output logic                   rd_we,
	input  wire logic              wr_pres_en,
	input  wire logic              wr_we_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [PRES_W-1:0] wr_pres,
	input  wire logic              wr_we
);

	logic [PRES_W-1:0] pres_mem [0:(1 << ADDR_W)-1];
	logic              we_mem   [0:(1 << ADDR_W)-1];

	// Write port, one enable per field.
	always_ff @(posedge clk) begin
		if (wr_pres_en) begin
			pres_mem[wr_addr] <= wr_pres;
		end
		if (wr_we_en) begin
			we_mem[wr_addr] <= wr_we;
		end
	end

	// Read port; both fields of one entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pres <= pres_mem[rd_addr];
			rd_we   <= we_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/tilu_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

// Walk sequencer: issues the reads for one letter, decides on the returned
// entries and writes back links, masks and word marks.
module tilu_ctrl #(
	parameter int NODE_COUNT    = 256,
	parameter int ALPHABET_SIZE = 26,
	localparam int NODE_W = $clog2(NODE_COUNT),
	localparam int LTR_W  = $clog2(ALPHABET_SIZE),
	localparam int CNT_W  = NODE_W + 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire tilu_pkg::mode_t                 in_mode,
	input  wire logic [tilu_pkg::LETTER_W-1:0]   in_letter,
	input  wire logic                            in_last,
	input  wire logic                            out_busy,
	output tilu_pkg::res_t                       res,
	output logic                                 ch_rd_en,
	output logic [NODE_W+LTR_W-1:0]              ch_rd_addr,
	input  wire logic [NODE_W-1:0]               ch_rd_data,
	output logic                                 ch_wr_en,
	output logic [NODE_W+LTR_W-1:0]              ch_wr_addr,
	output logic [NODE_W-1:0]                    ch_wr_data,
	output logic                                 nd_rd_en,
	output logic [NODE_W-1:0]                    nd_rd_addr,
	input  wire logic [ALPHABET_SIZE-1:0]        nd_rd_pres,
	input  wire logic                            nd_rd_we,
	output logic                                 nd_wr_pres_en,
	output logic                                 nd_wr_we_en,
	output logic [NODE_W-1:0]                    nd_wr_addr,
	output logic [ALPHABET_SIZE-1:0]             nd_wr_pres,
	output logic                                 nd_wr_we
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_INIT = 4'b0100,
		S_FEND = 4'b1000
	} state_t;

	state_t                 state_q, state_d;
	tilu_pkg::mode_t        mode_s1;
	logic [LTR_W-1:0]       ltr_s1;
	logic                   inrange_s1;
	logic                   last_s1;
	logic [NODE_W-1:0]      cursor_q;
	logic [CNT_W-1:0]       used_q;
	logic                   failed_q;
	logic                   root_pres_ok_q;
	logic                   root_we_ok_q;
	logic [NODE_W-1:0]      fresh_q;

	logic                   accept;
	logic [LTR_W-1:0]       in_ltr;
	logic                   in_range;
	logic [ALPHABET_SIZE-1:0] pres_vec;
	logic                   we_cur;
	logic                   is_ins, is_find, is_clr;
	logic                   do_walk, hit, room, alloc, fail_now, fail_next;
	logic [NODE_W-1:0]      fresh, dest;
	logic                   go_fend, has_res, blocked, adv, fend_done;
	logic                   we_mark;
	tilu_pkg::status_t      walk_status;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign in_ltr   = LTR_W'(in_letter);
	assign in_range = (32'(in_letter) < ALPHABET_SIZE);

	// Entries of the root read as empty until written after reset or clear.
	assign pres_vec = (cursor_q == '0 && !root_pres_ok_q) ? '0 : nd_rd_pres;
	assign we_cur   = (cursor_q == '0 && !root_we_ok_q) ? 1'b0 : nd_rd_we;

	// Decision for the letter whose entries have just returned.
	assign is_ins    = (mode_s1 == tilu_pkg::MODE_INSERT);
	assign is_find   = (mode_s1 == tilu_pkg::MODE_FIND);
	assign is_clr    = (mode_s1 == tilu_pkg::MODE_CLEAR);
	assign do_walk   = (is_ins || is_find) && !failed_q && inrange_s1;
	assign hit       = do_walk && pres_vec[ltr_s1];
	assign room      = (used_q < CNT_W'(NODE_COUNT));
	assign alloc     = do_walk && !hit && is_ins && room;
	assign fail_now  = do_walk && !hit && !alloc;
	assign fail_next = failed_q || fail_now;
	assign fresh     = used_q[NODE_W-1:0];
	assign dest      = hit ? ch_rd_data : (alloc ? fresh : cursor_q);
	assign go_fend   = hit && is_find && last_s1;
	assign has_res   = is_clr || ((is_ins || is_find) && last_s1 && !go_fend);
	assign blocked   = has_res && out_busy;
	assign adv       = (state_q == S_WALK) && !blocked;
	assign fend_done = (state_q == S_FEND) && !out_busy;
	assign we_mark   = adv && is_ins && last_s1 && !fail_next && !alloc;

	// Status of a key that ends in the walk cycle.
	always_comb begin
		if (is_clr) begin
			walk_status = tilu_pkg::ST_CLEARED;
		end else if (is_ins) begin
			walk_status = fail_next ? tilu_pkg::ST_POOL_FULL : tilu_pkg::ST_INSERTED;
		end else if (!fail_next && we_cur) begin
			walk_status = tilu_pkg::ST_FOUND;
		end else begin
			walk_status = tilu_pkg::ST_NOT_FOUND;
		end
	end

	// Result toward the output register.
	always_comb begin
		res.vld    = (adv && has_res) || fend_done;
		res.status = (state_q == S_FEND)
			? (nd_rd_we ? tilu_pkg::ST_FOUND : tilu_pkg::ST_NOT_FOUND)
			: walk_status;
	end

	// Memory read requests: entries of the cursor on accept, the word mark of
	// the reached child before a find answers.
	assign ch_rd_en   = accept;
	assign ch_rd_addr = {cursor_q, in_ltr};
	assign nd_rd_en   = accept || (adv && go_fend);
	assign nd_rd_addr = accept ? cursor_q : ch_rd_data;

	// Memory writes: new link and parent mask in the walk cycle, the fresh
	// node's entry in the cycle after it, or a word mark on an existing node.
	assign ch_wr_en      = adv && alloc;
	assign ch_wr_addr    = {cursor_q, ltr_s1};
	assign ch_wr_data    = fresh;
	assign nd_wr_pres_en = (adv && alloc) || (state_q == S_INIT);
	assign nd_wr_we_en   = we_mark || (state_q == S_INIT);
	assign nd_wr_addr    = (state_q == S_INIT) ? fresh_q : (alloc ? cursor_q : dest);
	assign nd_wr_pres    = (state_q == S_INIT)
		? '0 : (pres_vec | (ALPHABET_SIZE'(1) << ltr_s1));
	assign nd_wr_we      = (state_q == S_INIT) ? last_s1 : 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (adv) begin
					if (alloc) begin
						state_d = S_INIT;
					end else if (go_fend) begin
						state_d = S_FEND;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_INIT: begin
				state_d = S_IDLE;
			end
			S_FEND: begin
				if (!out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= in_mode;
			ltr_s1     <= in_ltr;
			inrange_s1 <= in_range;
			last_s1    <= in_last;
		end
		if (adv) begin
			fresh_q <= fresh;
		end
	end

	// Trie control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cursor_q       <= '0;
			used_q         <= CNT_W'(1);
			failed_q       <= 1'b0;
			root_pres_ok_q <= 1'b0;
			root_we_ok_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				if (is_clr) begin
					cursor_q       <= '0;
					used_q         <= CNT_W'(1);
					failed_q       <= 1'b0;
					root_pres_ok_q <= 1'b0;
					root_we_ok_q   <= 1'b0;
				end else if (is_ins || is_find) begin
					if (last_s1) begin
						cursor_q <= '0;
						failed_q <= 1'b0;
					end else begin
						cursor_q <= dest;
						failed_q <= fail_next;
					end
					if (alloc) begin
						used_q <= used_q + CNT_W'(1);
						if (cursor_q == '0) begin
							root_pres_ok_q <= 1'b1;
						end
					end
					if (we_mark && dest == '0) begin
						root_we_ok_q <= 1'b1;
					end
				end
			end
		end
	end

	`ASSERT_CLK(a_cursor_allocated, cursor_q < used_q, "cursor beyond allocated nodes")
	`ASSERT_CLK(a_used_bounds, (used_q != '0) && (used_q <= CNT_W'(NODE_COUNT)),
		"node count out of bounds")
	`ASSERT_CLK(a_init_after_walk, (state_q == S_INIT) |-> $past(state_q == S_WALK),
		"node init without a preceding walk")
	`ASSERT_NEVER(a_res_not_walk, res.vld && (state_q == S_IDLE || state_q == S_INIT),
		"result outside a deciding cycle")

endmodule

`default_nettype wire
